FILE: design/hae_pkg.sv
// Shared types and constants for the hybrid A* successor expansion block.
// Holds the polynomial coefficients, configuration register indexes and
// the structs that pass between the top level and the successor sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hae_pkg;

  localparam int NUM_DIRECTIONS = 3;
  localparam int NUM_SUCC       = 2 * NUM_DIRECTIONS;
  localparam int TRIG_BITS_DEF  = 10;

  // Horner stages of the quarter-wave polynomial and latency of a sine lane.
  localparam int HORNER   = 4;
  localparam int SINE_LAT = HORNER + 3;

  // Odd polynomial for sin(pi/2*z), Q30, highest order first.
  localparam logic [31:0] POLY_COEF [HORNER+1] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  typedef enum logic [2:0] {
    CFG_STRAIGHT_STEP   = 3'd0,
    CFG_TURN_STEP       = 3'd1,
    CFG_LATERAL_OFFSET  = 3'd2,
    CFG_HEADING_STEP    = 3'd3,
    CFG_TURN_PENALTY    = 3'd4,
    CFG_REVERSE_PENALTY = 3'd5,
    CFG_SWITCH_PENALTY  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [13:0] straight_step;
    logic [13:0] turn_step;
    logic [13:0] lateral_offset;
    logic [14:0] heading_step;
    logic [11:0] turn_penalty;
    logic [11:0] reverse_penalty;
    logic [11:0] switch_penalty;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        heading;
    logic [31:0]        cost;
    logic [2:0]         prim;
  } parent_t;

  localparam logic [2:0] LAST_SUCC = 3'(NUM_SUCC - 1);
  localparam logic [11:0] PEN_UNIT = 12'd256;

endpackage

`default_nettype wire

FILE: design/hae_sine.sv
// One sine lane: quarter-wave polynomial in a chain of registered Horner stages.
// Depends on hae_pkg for the coefficients and the Horner stage count.
`timescale 1ns / 1ps
`default_nettype none

module hae_sine #(
  parameter int TRIG_BITS = hae_pkg::TRIG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [14:0]                 u,
  input  logic                        neg,
  output logic signed [TRIG_BITS+1:0] value
);
  import hae_pkg::*;

  logic [14:0] u_p  [HORNER+1];
  logic        n_p  [HORNER+1];
  logic [31:0] z2_p [HORNER+1];
  logic [31:0] p_p  [HORNER+1];
  logic [30:0] m;
  logic        n_m;
  logic [46:0] m_full;
  logic [31:0] m_rnd;

  // First stage squares the argument: (u<<16)^2 >> 30 equals u*u*4.
  always_ff @(posedge clk) begin
    if (en) begin
      u_p[0]  <= u;
      n_p[0]  <= neg;
      z2_p[0] <= {30'(u) * 30'(u), 2'b00};
      p_p[0]  <= POLY_COEF[0];
    end
  end

  for (genvar j = 1; j <= HORNER; j++) begin : g_horner
    logic [63:0] prod;
    assign prod = z2_p[j-1] * p_p[j-1];
    always_ff @(posedge clk) begin
      if (en) begin
        u_p[j]  <= u_p[j-1];
        n_p[j]  <= n_p[j-1];
        z2_p[j] <= z2_p[j-1];
        p_p[j]  <= POLY_COEF[j] - prod[61:30];
      end
    end
  end

  // Final multiply by z: (u<<16)*p >> 30 equals u*p >> 14.
  assign m_full = u_p[HORNER] * p_p[HORNER];
  assign m_rnd  = {1'b0, m} + (32'd1 << (29 - TRIG_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      m     <= m_full[44:14];
      n_m   <= n_p[HORNER];
      value <= n_m ? -$signed({1'b0, m_rnd[30:30-TRIG_BITS]})
                   :  $signed({1'b0, m_rnd[30:30-TRIG_BITS]});
    end
  end

endmodule

`default_nettype wire

FILE: design/hae_expand.sv
// Successor sequencer and three-stage successor arithmetic pipeline.
// Depends on hae_pkg for the configuration and parent structs.
`timescale 1ns / 1ps
`default_nettype none

module hae_expand #(
  parameter int TRIG_BITS = hae_pkg::TRIG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hae_pkg::cfg_t               cfg,
  input  logic                        pvalid,
  input  hae_pkg::parent_t            parent,
  input  logic signed [TRIG_BITS+1:0] psin,
  input  logic signed [TRIG_BITS+1:0] pcos,
  output logic                        ready,
  input  logic                        stall,
  output logic                        out_valid,
  output logic signed [23:0]          succ_x,
  output logic signed [23:0]          succ_y,
  output logic [15:0]                 succ_heading,
  output logic [31:0]                 succ_cost,
  output logic [2:0]                  primitive_res,
  output logic                        last
);
  import hae_pkg::*;

  localparam int PW = TRIG_BITS + 17;

  logic                        en;
  logic                        busy;
  logic [2:0]                  idx;
  parent_t                     par;
  logic signed [TRIG_BITS+1:0] s_r, c_r;

  // Stage 1 selection.
  logic [1:0]          k;
  logic                rev;
  logic [13:0]         dx;
  logic signed [14:0]  fx, dy;
  logic [15:0]         dt;
  logic [11:0]         m1, m2, m3;

  logic                 v1;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic [25:0]          ca;
  logic [23:0]          cb;
  logic signed [23:0]   px1, py1;
  logic [15:0]          th1;
  logic [31:0]          g1;
  logic [2:0]           i1;

  logic                 v2;
  logic signed [PW:0]   ox_raw, oy_raw;
  logic [49:0]          inc_full;
  logic signed [23:0]   px2, py2;
  logic [15:0]          th2;
  logic [31:0]          g2;
  logic [2:0]           i2;

  logic signed [PW:0]   ox_sum, oy_sum, ox_sh, oy_sh;
  logic [50:0]          inc_rnd;
  logic [32:0]          total;

  assign en    = !out_valid || !stall;
  assign ready = en && (!busy || idx == LAST_SUCC);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (ready) begin
      busy <= pvalid;
      idx  <= '0;
    end else if (en && busy) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && pvalid) begin
      par <= parent;
      s_r <= psin;
      c_r <= pcos;
    end
  end

  always_comb begin
    rev = idx >= 3'(NUM_DIRECTIONS);
    k   = rev ? 2'(idx - 3'(NUM_DIRECTIONS)) : idx[1:0];
    dx  = (k == 2'd0) ? cfg.straight_step : cfg.turn_step;
    fx  = rev ? -$signed({1'b0, dx}) : $signed({1'b0, dx});
    case (k)
      2'd1: begin
        dy = -$signed({1'b0, cfg.lateral_offset});
        dt = {1'b0, cfg.heading_step};
      end
      2'd2: begin
        dy = $signed({1'b0, cfg.lateral_offset});
        dt = 16'd0 - {1'b0, cfg.heading_step};
      end
      default: begin
        dy = '0;
        dt = '0;
      end
    endcase
    m1 = PEN_UNIT;
    m2 = PEN_UNIT;
    m3 = PEN_UNIT;
    if (!rev) begin
      if (par.prim != idx) begin
        m1 = cfg.turn_penalty;
        if (par.prim > 3'd2) m2 = cfg.switch_penalty;
      end
    end else begin
      m1 = cfg.reverse_penalty;
      if (par.prim != idx) begin
        m2 = cfg.turn_penalty;
        if (par.prim < 3'd3) m3 = cfg.switch_penalty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= busy;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= PW'(fx * c_r);
      p_ys <= PW'(dy * s_r);
      p_xs <= PW'(fx * s_r);
      p_yc <= PW'(dy * c_r);
      ca   <= cfg.straight_step * m1;
      cb   <= m2 * m3;
      px1  <= par.pos_x;
      py1  <= par.pos_y;
      th1  <= rev ? par.heading - dt : par.heading + dt;
      g1   <= par.cost;
      i1   <= idx;

      ox_raw   <= (PW+1)'(p_xc) - (PW+1)'(p_ys);
      oy_raw   <= (PW+1)'(p_xs) + (PW+1)'(p_yc);
      inc_full <= ca * cb;
      px2      <= px1;
      py2      <= py1;
      th2      <= th1;
      g2       <= g1;
      i2       <= i1;
    end
  end

  // Round half up from Q(12+TRIG_BITS) to Q12 and saturate the cost.
  always_comb begin
    ox_sum  = ox_raw + $signed((PW+1)'(1) << (TRIG_BITS - 1));
    oy_sum  = oy_raw + $signed((PW+1)'(1) << (TRIG_BITS - 1));
    ox_sh   = ox_sum >>> TRIG_BITS;
    oy_sh   = oy_sum >>> TRIG_BITS;
    inc_rnd = {1'b0, inc_full} + (51'd1 << 19);
    total   = {1'b0, g2} + {2'b00, inc_rnd[50:20]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      succ_x        <= px2 + ox_sh[23:0];
      succ_y        <= py2 + oy_sh[23:0];
      succ_heading  <= th2;
      succ_cost     <= total[32] ? 32'hFFFF_FFFF : total[31:0];
      primitive_res <= i2;
      last          <= i2 == LAST_SUCC;
    end
  end

endmodule

`default_nettype wire

FILE: design/hybrid_astar_node_expand.sv
// Top level of the hybrid A* successor expansion block: configuration
// registers, sine/cosine pipeline and the successor sequencer.
// Depends on hae_pkg, hae_sine and hae_expand.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Transaction
// in        input      in_valid / in_stall  one parent pose
// out       output     out_valid / out_stall one successor pose
// cfg       input      cfg_we               one register write
//
// A parent transaction yields six successor transactions, one per cycle while
// the output is not stalled; the six-slot successor sequencer takes the next
// parent as it issues the last successor. A parent passes the stage 0 register,
// the sine/cosine pipeline and the successor arithmetic. Reset clears all valid
// bits and loads the register defaults. A stalled output freezes the successor
// pipeline and a front pipeline with a full tail; nothing is lost or repeated.

module hybrid_astar_node_expand #(
  parameter int TRIG_BITS = hae_pkg::TRIG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        heading,
  input  logic [31:0]        cost_so_far,
  input  logic [2:0]         parent_primitive,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] succ_x,
  output logic signed [23:0] succ_y,
  output logic [15:0]        succ_heading,
  output logic [31:0]        succ_cost,
  output logic [2:0]         primitive_res,
  output logic               last
);
  import hae_pkg::*;

  cfg_t    cfg;
  logic    trig_en;
  logic    exp_ready;

  // Stage 0 holds the accepted parent and the folded sine/cosine arguments.
  logic        v0;
  parent_t     par0;
  logic [14:0] us, uc;
  logic        ns, nc;
  logic [15:0] hc;

  // Parent payload delayed alongside the sine lanes.
  logic    vd   [1:SINE_LAT];
  parent_t pd   [1:SINE_LAT];

  logic signed [TRIG_BITS+1:0] sin_v, cos_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.straight_step   <= 14'd2856;
      cfg.turn_step       <= 14'd2845;
      cfg.lateral_offset  <= 14'd249;
      cfg.heading_step    <= 15'd1820;
      cfg.turn_penalty    <= 12'd269;
      cfg.reverse_penalty <= 12'd512;
      cfg.switch_penalty  <= 12'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRAIGHT_STEP:   cfg.straight_step   <= cfg_data[13:0];
        CFG_TURN_STEP:       cfg.turn_step       <= cfg_data[13:0];
        CFG_LATERAL_OFFSET:  cfg.lateral_offset  <= cfg_data[13:0];
        CFG_HEADING_STEP:    cfg.heading_step    <= cfg_data;
        CFG_TURN_PENALTY:    cfg.turn_penalty    <= cfg_data[11:0];
        CFG_REVERSE_PENALTY: cfg.reverse_penalty <= cfg_data[11:0];
        CFG_SWITCH_PENALTY:  cfg.switch_penalty  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // The front pipeline moves whenever its tail is empty or the sequencer
  // takes the parent waiting there.
  assign trig_en  = !vd[SINE_LAT] || exp_ready;
  assign in_stall = !trig_en;

  // Fold the heading into a quarter wave: odd quadrants mirror the argument,
  // the lower half-turn keeps the sign. Cosine is the sine a quarter on.
  assign hc = heading + 16'h4000;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (trig_en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (trig_en) begin
      par0.pos_x   <= pos_x;
      par0.pos_y   <= pos_y;
      par0.heading <= heading;
      par0.cost    <= cost_so_far;
      par0.prim    <= parent_primitive;
      us <= heading[14] ? 15'd16384 - {1'b0, heading[13:0]} : {1'b0, heading[13:0]};
      ns <= heading[15];
      uc <= hc[14] ? 15'd16384 - {1'b0, hc[13:0]} : {1'b0, hc[13:0]};
      nc <= hc[15];
    end
  end

  for (genvar j = 1; j <= SINE_LAT; j++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j] <= 1'b0;
      end else if (trig_en) begin
        vd[j] <= (j == 1) ? v0 : vd[j == 1 ? 1 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (trig_en) begin
        pd[j] <= (j == 1) ? par0 : pd[j == 1 ? 1 : j-1];
      end
    end
  end

  hae_sine #(.TRIG_BITS(TRIG_BITS)) u_sin (
    .clk   (clk),
    .en    (trig_en),
    .u     (us),
    .neg   (ns),
    .value (sin_v)
  );

  hae_sine #(.TRIG_BITS(TRIG_BITS)) u_cos (
    .clk   (clk),
    .en    (trig_en),
    .u     (uc),
    .neg   (nc),
    .value (cos_v)
  );

  hae_expand #(.TRIG_BITS(TRIG_BITS)) u_expand (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pvalid        (vd[SINE_LAT]),
    .parent        (pd[SINE_LAT]),
    .psin          (sin_v),
    .pcos          (cos_v),
    .ready         (exp_ready),
    .stall         (out_stall),
    .out_valid     (out_valid),
    .succ_x        (succ_x),
    .succ_y        (succ_y),
    .succ_heading  (succ_heading),
    .succ_cost     (succ_cost),
    .primitive_res (primitive_res),
    .last          (last)
  );

endmodule

`default_nettype wire

FILE: design/hae_checker.sv
// Port-level checker for the successor expansion block, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module hae_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] succ_x,
  input logic [2:0]         primitive_res,
  input logic               last
);

  // A stalled result stays valid and keeps its x position and index.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(succ_x) && $stable(primitive_res))
    else $error("stalled output changed");

  // The last flag marks exactly the sixth successor.
  a_last_marks_six: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (primitive_res == 3'd5)))
    else $error("last flag does not match the final successor");

  // Successors of one parent leave back to back in primitive order.
  a_successor_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && primitive_res != 3'd5
      |=> out_valid && primitive_res == $past(primitive_res) + 3'd1)
    else $error("successor sequence broken");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind hybrid_astar_node_expand hae_checker u_hae_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .succ_x        (succ_x),
  .primitive_res (primitive_res),
  .last          (last)
);

`default_nettype wire
